/* rtl/rv32x_pkg.sv */
// ----------------------------------------------------------------------------
// rv32x_pkg: shared types and codes for the RV32I execute core
// Operation codes, access size codes, item structs and the stage result
// struct passed from the execute logic to the write-back stage.
// ----------------------------------------------------------------------------
package rv32x_pkg;

  // Default configuration
  localparam int unsigned DEF_DATA_BASE  = 1024;
  localparam int unsigned DEF_DATA_BYTES = 1024;
  localparam int unsigned DEF_NUM_REGS   = 32;

  // Operation codes
  localparam logic [4:0] OP_ADD   = 5'd0;
  localparam logic [4:0] OP_SUB   = 5'd1;
  localparam logic [4:0] OP_XOR   = 5'd2;
  localparam logic [4:0] OP_OR    = 5'd3;
  localparam logic [4:0] OP_AND   = 5'd4;
  localparam logic [4:0] OP_SLL   = 5'd5;
  localparam logic [4:0] OP_SRL   = 5'd6;
  localparam logic [4:0] OP_SRA   = 5'd7;
  localparam logic [4:0] OP_SLT   = 5'd8;
  localparam logic [4:0] OP_SLTU  = 5'd9;
  localparam logic [4:0] OP_LB    = 5'd10;
  localparam logic [4:0] OP_LH    = 5'd11;
  localparam logic [4:0] OP_LW    = 5'd12;
  localparam logic [4:0] OP_LBU   = 5'd13;
  localparam logic [4:0] OP_LHU   = 5'd14;
  localparam logic [4:0] OP_ADDI  = 5'd15;
  localparam logic [4:0] OP_XORI  = 5'd16;
  localparam logic [4:0] OP_ORI   = 5'd17;
  localparam logic [4:0] OP_ANDI  = 5'd18;
  localparam logic [4:0] OP_SLTI  = 5'd19;
  localparam logic [4:0] OP_SLTIU = 5'd20;
  localparam logic [4:0] OP_JALR  = 5'd21;
  localparam logic [4:0] OP_BEQ   = 5'd22;
  localparam logic [4:0] OP_BNE   = 5'd23;
  localparam logic [4:0] OP_BLT   = 5'd24;
  localparam logic [4:0] OP_BLTU  = 5'd25;
  localparam logic [4:0] OP_BGE   = 5'd26;
  localparam logic [4:0] OP_BGEU  = 5'd27;
  localparam logic [4:0] OP_LUI   = 5'd28;
  localparam logic [4:0] OP_JAL   = 5'd29;
  localparam logic [4:0] OP_STORE = 5'd30;

  // Access size codes (also the store_width field)
  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd2;
  localparam logic [1:0] SIZE_BAD  = 2'd3;

  // Input item
  typedef struct packed {
    logic [4:0]         req_type;
    logic [4:0]         src_a_index;
    logic [4:0]         src_b_index;
    logic [4:0]         dest_index;
    logic signed [31:0] immediate;
    logic [1:0]         store_width;
  } req_t;

  // Result item
  typedef struct packed {
    logic        status;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [31:0] write_value;
  } rsp_t;

  // Execute stage outcome, carried into write-back
  typedef struct packed {
    logic        bad;
    logic [31:0] next_pc;
    logic        wr;
    logic [31:0] value;
    logic        is_load;
    logic        is_store;
    logic [1:0]  mem_size;
    logic        ld_signed;
  } ex_res_t;

  // Data store control from the pipeline
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [1:0] size;
  } mem_ctl_t;

endpackage

/* rtl/rv32x_regfile.sv */
// ----------------------------------------------------------------------------
// rv32x_regfile: integer register file
// Two registered read ports with write-through bypass, one write port.
// Per-entry valid bits give the all-zero reset; x0 is never written.
// ----------------------------------------------------------------------------
module rv32x_regfile #(
  parameter int unsigned NUM_REGS = rv32x_pkg::DEF_NUM_REGS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  rd_a_index,
  input  logic [4:0]  rd_b_index,
  output logic [31:0] rd_a_data,
  output logic [31:0] rd_b_data,
  input  logic        wr_en,
  input  logic [4:0]  wr_index,
  input  logic [31:0] wr_data
);

  localparam int unsigned RIW = $clog2(NUM_REGS);
  localparam logic [5:0]  NR6 = 6'(NUM_REGS);

  logic [31:0]         regs [NUM_REGS];
  logic [NUM_REGS-1:0] valid;

  logic [RIW-1:0] a_idx, b_idx, w_idx;
  logic           a_hit, b_hit, a_byp, b_byp;
  logic           a_hit_q, b_hit_q, a_byp_q, b_byp_q;
  logic [31:0]    a_raw, b_raw, byp_q;

  assign a_idx = rd_a_index[RIW-1:0];
  assign b_idx = rd_b_index[RIW-1:0];
  assign w_idx = wr_index[RIW-1:0];

  // Read qualifiers: in range and written since reset, or same-cycle write
  always_comb begin
    a_hit = ({1'b0, rd_a_index} < NR6) && valid[a_idx];
    b_hit = ({1'b0, rd_b_index} < NR6) && valid[b_idx];
    a_byp = wr_en && (wr_index == rd_a_index);
    b_byp = wr_en && (wr_index == rd_b_index);
  end

  // Storage array with registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      regs[w_idx] <= wr_data;
    end
    if (rd_en) begin
      a_raw   <= regs[a_idx];
      b_raw   <= regs[b_idx];
      a_hit_q <= a_hit;
      b_hit_q <= b_hit;
      a_byp_q <= a_byp;
      b_byp_q <= b_byp;
      byp_q   <= wr_data;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[w_idx] <= 1'b1;
    end
  end

  assign rd_a_data = a_byp_q ? byp_q : (a_hit_q ? a_raw : '0);
  assign rd_b_data = b_byp_q ? byp_q : (b_hit_q ? b_raw : '0);

endmodule

/* rtl/rv32x_dmem.sv */
// ----------------------------------------------------------------------------
// rv32x_dmem: big-endian byte data store
// Four byte-wide banks interleaved on the low offset bits, so any aligned or
// unaligned access of up to four bytes touches each bank at most once.
// A clearing pass zeroes one row per cycle after reset.
// ----------------------------------------------------------------------------
module rv32x_dmem #(
  parameter int unsigned DATA_BYTES = rv32x_pkg::DEF_DATA_BYTES
) (
  input  logic                                     clk,
  input  logic                                     rst,
  output logic                                     busy,
  input  rv32x_pkg::mem_ctl_t                      ctl,
  input  logic [$clog2((DATA_BYTES+3)/4)+1:0]      offset,
  input  logic [31:0]                              wdata,
  output logic [31:0]                              rdata
);

  localparam int unsigned ROWS = (DATA_BYTES + 3) / 4;
  localparam int unsigned RW   = $clog2(ROWS);

  logic [RW-1:0] clr_row;
  logic [RW-1:0] base_row;
  logic [1:0]    k_lo, k_lo_q;
  logic [31:0]   st_word, st_rot;
  logic [3:0]    st_mask, mask_rot;
  logic [63:0]   st_dbl, q_dbl;
  logic [7:0]    mask_dbl;
  logic [31:0]   q_word;

  assign base_row = offset[RW+1:2];
  assign k_lo     = offset[1:0];

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == RW'(ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Store bytes in address order (byte 0 in the top lane), then rotate to banks
  always_comb begin
    unique case (ctl.size)
      rv32x_pkg::SIZE_WORD: begin
        st_word = wdata;
        st_mask = 4'b1111;
      end
      rv32x_pkg::SIZE_HALF: begin
        st_word = {wdata[15:0], 16'h0000};
        st_mask = 4'b1100;
      end
      rv32x_pkg::SIZE_BYTE: begin
        st_word = {wdata[7:0], 24'h000000};
        st_mask = 4'b1000;
      end
      default: begin
        st_word = '0;
        st_mask = 4'b0000;
      end
    endcase
    st_dbl   = {st_word, st_word} >> {k_lo, 3'b000};
    st_rot   = st_dbl[31:0];
    mask_dbl = {st_mask, st_mask} >> k_lo;
    mask_rot = mask_dbl[3:0];
  end

  // Banks
  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [7:0]    mem [ROWS];
    logic [7:0]    q;
    logic [RW-1:0] row;
    logic [RW-1:0] wrow;
    logic          we;
    logic [7:0]    wd;

    // Bytes that wrap past bank 3 sit in the next row
    assign row  = (2'(j) < k_lo) ? base_row + 1'b1 : base_row;
    assign we   = busy || (ctl.wr_en && mask_rot[3-j]);
    assign wrow = busy ? clr_row : row;
    assign wd   = busy ? 8'h00 : st_rot[31-8*j -: 8];

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wrow] <= wd;
      end
      if (ctl.rd_en) begin
        q <= mem[row];
      end
    end

    assign q_word[31-8*j -: 8] = q;
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      k_lo_q <= k_lo;
    end
  end

  // Rotate banks back into address order: byte 0 in the top lane
  assign q_dbl = {q_word, q_word} << {k_lo_q, 3'b000};
  assign rdata = q_dbl[63:32];

endmodule

/* rtl/rv32x_alu.sv */
// ----------------------------------------------------------------------------
// rv32x_alu: execute logic
// ALU, branch decision, next PC, effective address and bounds check for one
// instruction. Pure combinational; sits between the issue and write-back
// registers.
// ----------------------------------------------------------------------------
module rv32x_alu #(
  parameter int unsigned DATA_BASE  = rv32x_pkg::DEF_DATA_BASE,
  parameter int unsigned DATA_BYTES = rv32x_pkg::DEF_DATA_BYTES,
  parameter int unsigned NUM_REGS   = rv32x_pkg::DEF_NUM_REGS
) (
  input  rv32x_pkg::req_t                      item,
  input  logic [31:0]                          a,
  input  logic [31:0]                          b,
  input  logic [31:0]                          pc,
  output rv32x_pkg::ex_res_t                   res,
  output logic [$clog2((DATA_BYTES+3)/4)+1:0]  offset
);

  localparam int unsigned OW     = $clog2((DATA_BYTES + 3) / 4) + 2;
  localparam logic [32:0] BASE33 = 33'(DATA_BASE);
  localparam logic [32:0] LIM_B  = 33'(DATA_BYTES - 1);
  localparam logic [32:0] LIM_H  = 33'(DATA_BYTES - 2);
  localparam logic [32:0] LIM_W  = 33'(DATA_BYTES - 4);
  localparam logic [5:0]  NR6    = 6'(NUM_REGS);

  logic [4:0]  op;
  logic [31:0] imm, addr, pc4, br_tgt, val, npc;
  logic [32:0] off, lim;
  logic [4:0]  sh;
  logic [1:0]  size;
  logic        is_load, is_store, in_range, bad, want, dest_ok;

  always_comb begin
    op     = item.req_type;
    imm    = $unsigned(item.immediate);
    sh     = b[4:0];
    addr   = a + imm;
    off    = {1'b0, addr} - BASE33;
    pc4    = pc + 32'd4;
    br_tgt = pc + {imm[30:0], 1'b0};

    is_load  = (op == rv32x_pkg::OP_LB) || (op == rv32x_pkg::OP_LH) ||
               (op == rv32x_pkg::OP_LW) || (op == rv32x_pkg::OP_LBU) ||
               (op == rv32x_pkg::OP_LHU);
    is_store = (op == rv32x_pkg::OP_STORE);

    // Access size
    if (is_store) begin
      size = item.store_width;
    end else if ((op == rv32x_pkg::OP_LB) || (op == rv32x_pkg::OP_LBU)) begin
      size = rv32x_pkg::SIZE_BYTE;
    end else if ((op == rv32x_pkg::OP_LH) || (op == rv32x_pkg::OP_LHU)) begin
      size = rv32x_pkg::SIZE_HALF;
    end else begin
      size = rv32x_pkg::SIZE_WORD;
    end

    // Bounds: every byte of the access inside the store
    unique case (size)
      rv32x_pkg::SIZE_BYTE: lim = LIM_B;
      rv32x_pkg::SIZE_HALF: lim = LIM_H;
      default:              lim = LIM_W;
    endcase
    in_range = !off[32] && (off <= lim);
    bad = (is_load || is_store) &&
          (!in_range || (is_store && (item.store_width == rv32x_pkg::SIZE_BAD)));

    // Operation
    val  = '0;
    want = 1'b0;
    npc  = pc4;
    unique case (op)
      rv32x_pkg::OP_ADD:   begin val = a + b;  want = 1'b1; end
      rv32x_pkg::OP_SUB:   begin val = a - b;  want = 1'b1; end
      rv32x_pkg::OP_XOR:   begin val = a ^ b;  want = 1'b1; end
      rv32x_pkg::OP_OR:    begin val = a | b;  want = 1'b1; end
      rv32x_pkg::OP_AND:   begin val = a & b;  want = 1'b1; end
      rv32x_pkg::OP_SLL:   begin val = a << sh; want = 1'b1; end
      rv32x_pkg::OP_SRL:   begin val = a >> sh; want = 1'b1; end
      rv32x_pkg::OP_SRA:   begin val = $unsigned($signed(a) >>> sh); want = 1'b1; end
      rv32x_pkg::OP_SLT:   begin val = {31'd0, $signed(a) < $signed(b)}; want = 1'b1; end
      rv32x_pkg::OP_SLTU:  begin val = {31'd0, a < b}; want = 1'b1; end
      rv32x_pkg::OP_LB,
      rv32x_pkg::OP_LH,
      rv32x_pkg::OP_LW,
      rv32x_pkg::OP_LBU,
      rv32x_pkg::OP_LHU:   want = 1'b1;
      rv32x_pkg::OP_ADDI:  begin val = addr;    want = 1'b1; end
      rv32x_pkg::OP_XORI:  begin val = a ^ imm; want = 1'b1; end
      rv32x_pkg::OP_ORI:   begin val = a | imm; want = 1'b1; end
      rv32x_pkg::OP_ANDI:  begin val = a & imm; want = 1'b1; end
      rv32x_pkg::OP_SLTI:  begin val = {31'd0, $signed(a) < $signed(imm)}; want = 1'b1; end
      rv32x_pkg::OP_SLTIU: begin val = {31'd0, a < imm}; want = 1'b1; end
      rv32x_pkg::OP_JALR: begin
        val  = pc4;
        want = 1'b1;
        npc  = {addr[31:1], 1'b0};
      end
      rv32x_pkg::OP_BEQ:   if (a == b) npc = br_tgt;
      rv32x_pkg::OP_BNE:   if (a != b) npc = br_tgt;
      rv32x_pkg::OP_BLT:   if ($signed(a) < $signed(b)) npc = br_tgt;
      rv32x_pkg::OP_BLTU:  if (a < b) npc = br_tgt;
      rv32x_pkg::OP_BGE:   if (!($signed(a) < $signed(b))) npc = br_tgt;
      rv32x_pkg::OP_BGEU:  if (!(a < b)) npc = br_tgt;
      rv32x_pkg::OP_LUI:   begin val = imm; want = 1'b1; end
      rv32x_pkg::OP_JAL: begin
        val  = pc4;
        want = 1'b1;
        npc  = br_tgt;
      end
      rv32x_pkg::OP_STORE: ;
      default: ;  // no operation
    endcase

    // x0 and out-of-range destinations are never written
    dest_ok = (item.dest_index != 5'd0) && ({1'b0, item.dest_index} < NR6);

    res.bad       = bad;
    res.next_pc   = bad ? pc : npc;
    res.wr        = want && !bad && dest_ok;
    res.value     = (res.wr && !is_load) ? val : '0;
    res.is_load   = is_load && !bad;
    res.is_store  = is_store && !bad;
    res.mem_size  = size;
    res.ld_signed = (op == rv32x_pkg::OP_LB) || (op == rv32x_pkg::OP_LH);

    offset = off[OW-1:0];
  end

endmodule

/* rtl/rv32i_execute_core.sv */
// ----------------------------------------------------------------------------
// rv32i_execute_core: RV32I integer execute core
// An accepted item passes the issue, write-back and result registers to rsp.
// Throughput: one item per cycle while rsp_stall and the data store clearing
// allow it, bounded by the single data store access and register write per
// item; results forwarded. Reset clears the register file and PC, then zeroes
// the data store one row of four bytes per cycle, holding req_stall high.
// ----------------------------------------------------------------------------
module rv32i_execute_core #(
  parameter int unsigned DATA_BASE  = rv32x_pkg::DEF_DATA_BASE,
  parameter int unsigned DATA_BYTES = rv32x_pkg::DEF_DATA_BYTES,
  parameter int unsigned NUM_REGS   = rv32x_pkg::DEF_NUM_REGS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  rv32x_pkg::req_t   req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rv32x_pkg::rsp_t   rsp
);

  localparam int unsigned OW = $clog2((DATA_BYTES + 3) / 4) + 2;

  // Stage handshake
  logic accept, out_load, wb_free, wb_fire, ex_free, ex_fire, mem_busy;

  // Execute stage
  logic               ex_valid;
  rv32x_pkg::req_t    ex_item;
  logic [31:0]        rf_a, rf_b, op_a, op_b;
  logic [31:0]        pc;
  rv32x_pkg::ex_res_t ex_res;
  logic [OW-1:0]      ex_offset;
  rv32x_pkg::mem_ctl_t mem_ctl;

  // Write-back stage
  logic               wb_valid;
  rv32x_pkg::ex_res_t wb_res;
  logic [4:0]         wb_dest;
  logic [31:0]        ld_word, ld_value, wb_value;
  logic               ld_sign;

  assign out_load  = !rsp_valid || !rsp_stall;
  assign wb_free   = !wb_valid || out_load;
  assign wb_fire   = wb_valid && out_load;
  assign ex_free   = !ex_valid || wb_free;
  assign ex_fire   = ex_valid && wb_free;
  assign req_stall = mem_busy || !ex_free;
  assign accept    = req_valid && !req_stall;

  // Register file
  rv32x_regfile #(
    .NUM_REGS (NUM_REGS)
  ) u_regfile (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_a_index (req.src_a_index),
    .rd_b_index (req.src_b_index),
    .rd_a_data  (rf_a),
    .rd_b_data  (rf_b),
    .wr_en      (wb_fire && wb_res.wr),
    .wr_index   (wb_dest),
    .wr_data    (wb_value)
  );

  // Issue register
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (ex_free) begin
      ex_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_item <= req;
    end
  end

  // Forward the write-back result that has not reached the register file
  always_comb begin
    op_a = rf_a;
    op_b = rf_b;
    if (wb_valid && wb_res.wr && (wb_dest == ex_item.src_a_index)) begin
      op_a = wb_value;
    end
    if (wb_valid && wb_res.wr && (wb_dest == ex_item.src_b_index)) begin
      op_b = wb_value;
    end
  end

  rv32x_alu #(
    .DATA_BASE  (DATA_BASE),
    .DATA_BYTES (DATA_BYTES),
    .NUM_REGS   (NUM_REGS)
  ) u_alu (
    .item   (ex_item),
    .a      (op_a),
    .b      (op_b),
    .pc     (pc),
    .res    (ex_res),
    .offset (ex_offset)
  );

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (ex_fire) begin
      pc <= ex_res.next_pc;
    end
  end

  // Data store: store written and load read as the item leaves execute
  assign mem_ctl = '{wr_en: ex_fire && ex_res.is_store,
                     rd_en: ex_fire,
                     size:  ex_res.mem_size};

  rv32x_dmem #(
    .DATA_BYTES (DATA_BYTES)
  ) u_dmem (
    .clk    (clk),
    .rst    (rst),
    .busy   (mem_busy),
    .ctl    (mem_ctl),
    .offset (ex_offset),
    .wdata  (op_b),
    .rdata  (ld_word)
  );

  // Write-back register
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (wb_free) begin
      wb_valid <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      wb_res  <= ex_res;
      wb_dest <= ex_item.dest_index;
    end
  end

  // Load alignment and extension
  always_comb begin
    ld_sign = wb_res.ld_signed && ld_word[31];
    unique case (wb_res.mem_size)
      rv32x_pkg::SIZE_BYTE: ld_value = {{24{ld_sign}}, ld_word[31:24]};
      rv32x_pkg::SIZE_HALF: ld_value = {{16{ld_sign}}, ld_word[31:16]};
      default:              ld_value = ld_word;
    endcase
    wb_value = (wb_res.is_load && wb_res.wr) ? ld_value : wb_res.value;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= wb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= '{status:      wb_res.bad,
               next_pc:     wb_res.next_pc,
               reg_write:   wb_res.wr,
               write_value: wb_value};
    end
  end

endmodule

/* rtl/rv32x_checker.sv */
// ----------------------------------------------------------------------------
// rv32x_checker: port-level checks for the execute core
// Reset clearing stall, result consistency, hold under stall and latency.
// ----------------------------------------------------------------------------
module rv32x_checker (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input rv32x_pkg::rsp_t rsp
);

  // Data store clearing holds off items right after reset
  a_clear_stall: assert property (@(posedge clk) $fell(rst) |-> req_stall)
    else $error("item taken during data store clearing");

  // An illegal access writes nothing
  a_bad_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> !rsp.reg_write && (rsp.write_value == 32'd0))
    else $error("illegal access reported a register write");

  // No write-back means a zero value
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.reg_write |-> (rsp.write_value == 32'd0))
    else $error("write_value nonzero without reg_write");

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed under stall");

  // An accepted item reaches rsp through an unstalled pipe
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
    else $error("result late");

endmodule

bind rv32i_execute_core rv32x_checker u_checker (.*);
